// ===== rtl/effective_address_specifier_decoder_assert.svh =====
// Assertion macros shared by the decoder modules.
`ifndef EFFECTIVE_ADDRESS_SPECIFIER_DECODER_ASSERT_SVH
`define EFFECTIVE_ADDRESS_SPECIFIER_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EASD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// The consequent must hold in the cycle after the antecedent.
`define EASD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

// ===== rtl/easd_pkg.sv =====
package easd_pkg;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_EA,
      PH_SCALED,
      PH_IDX1,
      PH_IDX2,
      PH_PC1,
      PH_PC2,
      PH_DI,
      PH_GATHER
   } phase_type;

   localparam logic [3:0] MODE_REG       = 4'd0;
   localparam logic [3:0] MODE_IND       = 4'd1;
   localparam logic [3:0] MODE_DISP      = 4'd2;
   localparam logic [3:0] MODE_POSTINC   = 4'd3;
   localparam logic [3:0] MODE_PREDEC    = 4'd4;
   localparam logic [3:0] MODE_IMM       = 4'd5;
   localparam logic [3:0] MODE_ABS       = 4'd6;
   localparam logic [3:0] MODE_SCALED    = 4'd7;
   localparam logic [3:0] MODE_INDEXED   = 4'd8;
   localparam logic [3:0] MODE_PCREL     = 4'd9;
   localparam logic [3:0] MODE_PCREL_IDX = 4'd10;
   localparam logic [3:0] MODE_DOUBLE    = 4'd11;
   localparam logic [3:0] MODE_INVALID   = 4'd12;

   localparam logic [1:0] BANK_GENERAL = 2'd0;
   localparam logic [1:0] BANK_CONTROL = 2'd1;
   localparam logic [1:0] BANK_PAGE    = 2'd2;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL_MODE = 2'd1;
   localparam logic [1:0] STATUS_ILLEGAL_OPND = 2'd2;

   localparam logic [1:0] SIZE_NONE = 2'd0;
   localparam logic [1:0] SIZE_BYTE = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_LONG = 2'd3;

   localparam logic [1:0] DEST_VALUE = 2'd0;
   localparam logic [1:0] DEST_INNER = 2'd1;
   localparam logic [1:0] DEST_OUTER = 2'd2;

   typedef struct packed {
      logic [3:0]         addr_mode;
      logic [3:0]         base_reg;
      logic [1:0]         reg_bank;
      logic [3:0]         index_reg;
      logic               index_long;
      logic [1:0]         scale_shift;
      logic [1:0]         field_size;
      logic signed [31:0] disp_inner;
      logic signed [31:0] disp_outer;
      logic [31:0]        value;
      logic               accumulator;
      logic [1:0]         status;
   } result_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [3:0]  base;
      logic [3:0]  idx;
      logic        idx_long;
      logic [1:0]  shift;
      logic [1:0]  fsize;
      logic        acc;
      logic [1:0]  dest;
      logic [1:0]  s2;
      logic [31:0] inner;
      logic [31:0] outer;
      logic [31:0] value;
   } fields_type;

   function automatic logic [31:0] sign_extend(input logic [31:0] v, input logic [1:0] sz);
      logic [31:0] r;
      case (sz)
         SIZE_BYTE: r = {{24{v[7]}}, v[7:0]};
         SIZE_WORD: r = {{16{v[15]}}, v[15:0]};
         default:   r = v;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/easd_decode.sv =====
`include "effective_address_specifier_decoder_assert.svh"

module easd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           spec_byte,
   input  logic                 start_req,
   input  logic [2:0]           operand_kind,
   input  logic [31:0]          next_address,
   output logic                 emit,
   output easd_pkg::result_type result
);

   localparam logic [2:0] GRP_REG     = 3'd4;
   localparam logic [2:0] GRP_POSTINC = 3'd5;
   localparam logic [2:0] GRP_PREDEC  = 3'd6;

   localparam logic [3:0] EXT_CTRL_PREFIX = 4'h0;
   localparam logic [3:0] EXT_PAGE_PREFIX = 4'h4;
   localparam logic [3:0] EXT_INDEXED     = 4'hC;
   localparam logic [3:0] EXT_PCREL       = 4'hD;
   localparam logic [3:0] EXT_DOUBLE      = 4'hE;

   localparam logic [2:0] KIND_ANY      = 3'd0;
   localparam logic [2:0] KIND_MEMORY   = 3'd2;
   localparam logic [2:0] KIND_PERIPH   = 3'd3;
   localparam logic [2:0] KIND_BITFIELD = 3'd4;

   easd_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           bytes_left_ff, bytes_left_in;
   logic [1:0]           bank_ff, bank_in;
   logic [2:0]           kind_ff, kind_in;
   easd_pkg::fields_type work_ff, work_in;
   logic [31:0]          assembly_ff, assembly_in;
   logic [1:0]           error_ff, error_in;

   logic                 do_gather;
   logic                 do_finish;
   logic [1:0]           gather_size;
   logic [1:0]           gather_dest;
   logic [6:0]           code;
   logic [2:0]           grp;
   logic [31:0]          extended;
   easd_pkg::phase_type  phase_cur;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      bank_in       = bank_ff;
      kind_in       = kind_ff;
      work_in       = work_ff;
      assembly_in   = assembly_ff;
      error_in      = error_ff;
      do_gather     = 1'b0;
      do_finish     = 1'b0;
      gather_size   = easd_pkg::SIZE_NONE;
      gather_dest   = easd_pkg::DEST_INNER;
      code          = spec_byte[6:0];
      grp           = spec_byte[6:4];
      extended      = '0;
      phase_cur     = phase_ff;
      emit          = 1'b0;

      if (start_req) begin
         work_in       = '0;
         bank_in       = easd_pkg::BANK_GENERAL;
         error_in      = easd_pkg::STATUS_OK;
         bytes_left_in = '0;
         assembly_in   = '0;
         kind_in       = operand_kind;
         phase_cur     = easd_pkg::PH_EA;
      end

      case (phase_cur)
         easd_pkg::PH_EA: begin
            if (spec_byte[7]) begin
               work_in.acc = 1'b1;
            end
            if (grp == GRP_REG) begin
               if (kind_in == KIND_MEMORY || kind_in == KIND_PERIPH) begin
                  if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
               end
               work_in.mode = easd_pkg::MODE_REG;
               work_in.base = code[3:0];
               do_finish    = 1'b1;
            end else if (grp inside {[3'd0:3'd3]}) begin
               work_in.mode = (grp == 3'd0) ? easd_pkg::MODE_IND : easd_pkg::MODE_DISP;
               work_in.base = code[3:0];
               do_gather    = 1'b1;
               gather_size  = grp[1:0];
               gather_dest  = easd_pkg::DEST_INNER;
            end else if (grp == GRP_POSTINC || grp == GRP_PREDEC) begin
               if (kind_in == KIND_PERIPH || kind_in == KIND_BITFIELD) begin
                  if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
               end
               work_in.mode = (grp == GRP_POSTINC) ? easd_pkg::MODE_POSTINC
                                                   : easd_pkg::MODE_PREDEC;
               work_in.base = code[3:0];
               do_finish    = 1'b1;
            end else if (code[3:0] == EXT_CTRL_PREFIX || code[3:0] == EXT_PAGE_PREFIX) begin
               if (bank_in != easd_pkg::BANK_GENERAL) begin
                  if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
               end
               bank_in  = (code[3:0] == EXT_CTRL_PREFIX) ? easd_pkg::BANK_CONTROL
                                                         : easd_pkg::BANK_PAGE;
               phase_in = easd_pkg::PH_EA;
            end else if (code[3] == 1'b0) begin
               if (!code[2] && kind_in != KIND_ANY) begin
                  if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
               end
               if (bank_in != easd_pkg::BANK_GENERAL) begin
                  if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
               end
               work_in.mode = code[2] ? easd_pkg::MODE_ABS : easd_pkg::MODE_IMM;
               do_gather    = 1'b1;
               gather_size  = code[1:0];
               gather_dest  = easd_pkg::DEST_VALUE;
            end else if (code[2] == 1'b0) begin
               work_in.mode  = easd_pkg::MODE_SCALED;
               work_in.fsize = code[1:0];
               phase_in      = easd_pkg::PH_SCALED;
            end else if (code[3:0] == EXT_INDEXED) begin
               work_in.mode = easd_pkg::MODE_INDEXED;
               phase_in     = easd_pkg::PH_IDX1;
            end else if (code[3:0] == EXT_PCREL) begin
               if (bank_in != easd_pkg::BANK_GENERAL) begin
                  if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
               end
               phase_in = easd_pkg::PH_PC1;
            end else if (code[3:0] == EXT_DOUBLE) begin
               work_in.mode = easd_pkg::MODE_DOUBLE;
               phase_in     = easd_pkg::PH_DI;
            end else begin
               if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_OPND;
               work_in.mode = easd_pkg::MODE_INVALID;
               do_finish    = 1'b1;
            end
         end
         easd_pkg::PH_SCALED, easd_pkg::PH_IDX2, easd_pkg::PH_PC2: begin
            if (spec_byte[7:6] != 2'b00) begin
               if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
            end
            work_in.shift = spec_byte[5:4];
            work_in.idx   = spec_byte[3:0];
            if (phase_cur == easd_pkg::PH_SCALED) begin
               work_in.base = spec_byte[3:0];
            end
            do_gather   = 1'b1;
            gather_size = work_in.fsize;
            gather_dest = easd_pkg::DEST_INNER;
         end
         easd_pkg::PH_IDX1: begin
            if (spec_byte[7]) begin
               if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
            end
            work_in.fsize    = spec_byte[5:4];
            work_in.base     = spec_byte[3:0];
            work_in.idx_long = spec_byte[6];
            phase_in         = easd_pkg::PH_IDX2;
         end
         easd_pkg::PH_PC1: begin
            work_in.fsize = spec_byte[5:4];
            if (spec_byte[7]) begin
               work_in.mode = easd_pkg::MODE_PCREL;
               if (spec_byte[6] || spec_byte[3:0] != 4'h0) begin
                  if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
               end
               do_gather   = 1'b1;
               gather_size = spec_byte[5:4];
               gather_dest = easd_pkg::DEST_INNER;
            end else begin
               work_in.mode = easd_pkg::MODE_PCREL_IDX;
               if (spec_byte[3:0] != 4'h0) begin
                  if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
               end
               work_in.idx_long = spec_byte[6];
               phase_in         = easd_pkg::PH_PC2;
            end
         end
         easd_pkg::PH_DI: begin
            work_in.s2    = spec_byte[7:6];
            work_in.base  = spec_byte[3:0];
            work_in.fsize = spec_byte[5:4];
            if (!spec_byte[4] || !spec_byte[6]) begin
               if (error_in == easd_pkg::STATUS_OK) error_in = easd_pkg::STATUS_ILLEGAL_MODE;
            end
            do_gather   = 1'b1;
            gather_size = spec_byte[5:4];
            gather_dest = easd_pkg::DEST_INNER;
         end
         easd_pkg::PH_GATHER: begin
            assembly_in = {assembly_ff[23:0], spec_byte};
            if (bytes_left_ff != 3'd0) begin
               bytes_left_in = bytes_left_ff - 3'd1;
            end
            if (bytes_left_in == 3'd0) begin
               if (work_in.dest == easd_pkg::DEST_OUTER) begin
                  work_in.outer = easd_pkg::sign_extend(assembly_in, work_in.s2);
                  do_finish     = 1'b1;
               end else begin
                  extended = easd_pkg::sign_extend(assembly_in, work_in.fsize);
                  if (work_in.dest == easd_pkg::DEST_VALUE) begin
                     work_in.value = extended;
                     do_finish     = 1'b1;
                  end else begin
                     work_in.inner = extended;
                     if (work_in.mode == easd_pkg::MODE_DOUBLE) begin
                        do_gather   = 1'b1;
                        gather_size = work_in.s2;
                        gather_dest = easd_pkg::DEST_OUTER;
                     end else begin
                        do_finish = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (do_gather) begin
         if (gather_size == easd_pkg::SIZE_NONE && gather_dest == easd_pkg::DEST_INNER &&
             work_in.mode == easd_pkg::MODE_DOUBLE) begin
            gather_size = work_in.s2;
            gather_dest = easd_pkg::DEST_OUTER;
         end
         if (gather_size == easd_pkg::SIZE_NONE) begin
            do_finish = 1'b1;
         end else begin
            work_in.dest = gather_dest;
            if (gather_dest == easd_pkg::DEST_OUTER) begin
               work_in.s2 = gather_size;
            end else begin
               work_in.fsize = gather_size;
            end
            case (gather_size)
               easd_pkg::SIZE_BYTE: bytes_left_in = 3'd1;
               easd_pkg::SIZE_WORD: bytes_left_in = 3'd2;
               default:             bytes_left_in = 3'd4;
            endcase
            assembly_in = '0;
            phase_in    = easd_pkg::PH_GATHER;
         end
      end

      if (do_finish) begin
         if (work_in.mode == easd_pkg::MODE_PCREL || work_in.mode == easd_pkg::MODE_PCREL_IDX) begin
            work_in.value = next_address + work_in.inner;
         end
         emit          = accept;
         phase_in      = easd_pkg::PH_IDLE;
         bytes_left_in = '0;
      end
   end

   always_comb begin
      result.addr_mode   = work_in.mode;
      result.base_reg    = work_in.base;
      result.reg_bank    = bank_in;
      result.index_reg   = work_in.idx;
      result.index_long  = work_in.idx_long;
      result.scale_shift = work_in.shift;
      result.field_size  = work_in.fsize;
      result.disp_inner  = work_in.inner;
      result.disp_outer  = work_in.outer;
      result.value       = work_in.value;
      result.accumulator = work_in.acc;
      result.status      = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= easd_pkg::PH_IDLE;
         bytes_left_ff <= '0;
         bank_ff       <= easd_pkg::BANK_GENERAL;
         kind_ff       <= '0;
         work_ff       <= '0;
         assembly_ff   <= '0;
         error_ff      <= easd_pkg::STATUS_OK;
      end else if (accept) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         bank_ff       <= bank_in;
         kind_ff       <= kind_in;
         work_ff       <= work_in;
         assembly_ff   <= assembly_in;
         error_ff      <= error_in;
      end
   end

   `EASD_ASSERT_SAME(a_count_only_gathering, clock, reset, bytes_left_ff != 3'd0, phase_ff == easd_pkg::PH_GATHER)
   `EASD_ASSERT_SAME(a_invalid_flagged, clock, reset, emit && result.addr_mode == easd_pkg::MODE_INVALID, result.status != easd_pkg::STATUS_OK)
   `EASD_ASSERT_NEXT(a_emit_returns_idle, clock, reset, emit, phase_ff == easd_pkg::PH_IDLE && bytes_left_ff == 3'd0)

endmodule

// ===== rtl/easd_outbuf.sv =====
`include "effective_address_specifier_decoder_assert.svh"

module easd_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  easd_pkg::result_type push_word,
   output logic                 ready,
   output logic                 out_valid,
   input  logic                 out_stall,
   output easd_pkg::result_type out_word
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   easd_pkg::result_type main_word_ff, main_word_in;
   easd_pkg::result_type skid_word_ff, skid_word_in;
   logic                 pop;

   assign pop       = main_valid_ff && !out_stall;
   assign ready     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_word_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in  = main_word_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_word_in  = push_word;
            main_valid_in = 1'b1;
         end else begin
            skid_word_in  = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   `EASD_ASSERT_SAME(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   `EASD_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !out_stall, main_valid_ff && !skid_valid_ff)
   `EASD_ASSERT_NEXT(a_skid_catches, clock, reset, push && main_valid_ff && out_stall && !skid_valid_ff, skid_valid_ff)

endmodule

// ===== rtl/effective_address_specifier_decoder.sv =====
// Decodes an effective-address specifier arriving one byte per word on the req channel, a
// new specifier marked by req_start_req, and returns one rsp word per completed specifier
// with the decoded fields, the PC-relative target and a status. The phase and gathering
// registers update on each accepted byte, and a result is registered before it appears on
// rsp. An output register plus a one-word skid stage sit before rsp, so req_stall rises
// only when both hold words that rsp has not yet taken.
module effective_address_specifier_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_spec_byte,
   input  logic               req_start_req,
   input  logic [2:0]         req_operand_kind,
   input  logic [31:0]        req_next_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_addr_mode,
   output logic [3:0]         rsp_base_reg,
   output logic [1:0]         rsp_reg_bank,
   output logic [3:0]         rsp_index_reg,
   output logic               rsp_index_long,
   output logic [1:0]         rsp_scale_shift,
   output logic [1:0]         rsp_field_size,
   output logic signed [31:0] rsp_disp_inner,
   output logic signed [31:0] rsp_disp_outer,
   output logic [31:0]        rsp_value,
   output logic               rsp_accumulator,
   output logic [1:0]         rsp_status
);

   logic                 accept;
   logic                 ready;
   logic                 emit;
   easd_pkg::result_type result;
   easd_pkg::result_type out_word;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   easd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .spec_byte    (req_spec_byte),
      .start_req    (req_start_req),
      .operand_kind (req_operand_kind),
      .next_address (req_next_address),
      .emit         (emit),
      .result       (result)
   );

   easd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_word (result),
      .ready     (ready),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_addr_mode   = out_word.addr_mode;
   assign rsp_base_reg    = out_word.base_reg;
   assign rsp_reg_bank    = out_word.reg_bank;
   assign rsp_index_reg   = out_word.index_reg;
   assign rsp_index_long  = out_word.index_long;
   assign rsp_scale_shift = out_word.scale_shift;
   assign rsp_field_size  = out_word.field_size;
   assign rsp_disp_inner  = out_word.disp_inner;
   assign rsp_disp_outer  = out_word.disp_outer;
   assign rsp_value       = out_word.value;
   assign rsp_accumulator = out_word.accumulator;
   assign rsp_status      = out_word.status;

endmodule

// ===== dv/effective_address_specifier_decoder_tb.sv =====
module effective_address_specifier_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import easd_pkg::*;

   typedef logic [7:0] byte_list_t[$];

   localparam logic [2:0] KIND_ANY        = 3'd0;
   localparam logic [2:0] KIND_WRITE      = 3'd1;
   localparam logic [2:0] KIND_MEMORY     = 3'd2;
   localparam logic [2:0] KIND_PERIPHERAL = 3'd3;
   localparam logic [2:0] KIND_BITFIELD   = 3'd4;
   localparam logic [2:0] KIND_UNDEFINED  = 3'd6;

   localparam logic [2:0] GROUP_REG      = 3'd4;
   localparam logic [2:0] GROUP_POSTINC  = 3'd5;
   localparam logic [2:0] GROUP_EXTENDED = 3'd7;

   localparam logic [6:0] CODE_PREFIX_CONTROL = 7'h70;
   localparam logic [6:0] CODE_PREFIX_PAGE    = 7'h74;
   localparam logic [6:0] CODE_INDEXED        = 7'h7C;
   localparam logic [6:0] CODE_PCREL          = 7'h7D;
   localparam logic [6:0] CODE_DOUBLE         = 7'h7E;
   localparam logic [6:0] CODE_INVALID        = 7'h7F;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_spec_byte = '0;
   logic               req_start_req = 1'b0;
   logic [2:0]         req_operand_kind = '0;
   logic [31:0]        req_next_address = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_addr_mode;
   logic [3:0]         rsp_base_reg;
   logic [1:0]         rsp_reg_bank;
   logic [3:0]         rsp_index_reg;
   logic               rsp_index_long;
   logic [1:0]         rsp_scale_shift;
   logic [1:0]         rsp_field_size;
   logic signed [31:0] rsp_disp_inner;
   logic signed [31:0] rsp_disp_outer;
   logic [31:0]        rsp_value;
   logic               rsp_accumulator;
   logic [1:0]         rsp_status;

   phase_type   spec_phase;
   logic [2:0]  bytes_due;
   logic [1:0]  bank_held;
   logic [2:0]  kind_held;
   fields_type  spec;
   logic [31:0] gathered;
   logic [1:0]  status_held;

   result_type expected_results[$];
   int         mismatch_count = 0;
   int         send_gap_pct = 0;
   int         rsp_stall_pct = 0;

   effective_address_specifier_decoder dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [31:0] sign_widen(input logic [31:0] raw, input logic [1:0] size);
      case (size)
         SIZE_BYTE: return 32'(signed'(raw[7:0]));
         SIZE_WORD: return 32'(signed'(raw[15:0]));
         default:   return raw;
      endcase
   endfunction

   function automatic void flag_error(input logic [1:0] code);
      if (status_held == STATUS_OK)
         status_held = code;
   endfunction

   function automatic void take_index(input logic [7:0] b);
      if (b[7:6] != 2'b00)
         flag_error(STATUS_ILLEGAL_MODE);
      spec.shift = b[5:4];
      spec.idx = b[3:0];
   endfunction

   function automatic bit close_specifier(input logic [31:0] na, output result_type r);
      if (spec.mode == MODE_PCREL || spec.mode == MODE_PCREL_IDX)
         spec.value = na + spec.inner;
      r.addr_mode = spec.mode;
      r.base_reg = spec.base;
      r.reg_bank = bank_held;
      r.index_reg = spec.idx;
      r.index_long = spec.idx_long;
      r.scale_shift = spec.shift;
      r.field_size = spec.fsize;
      r.disp_inner = spec.inner;
      r.disp_outer = spec.outer;
      r.value = spec.value;
      r.accumulator = spec.acc;
      r.status = status_held;
      spec_phase = PH_IDLE;
      bytes_due = '0;
      return 1'b1;
   endfunction

   function automatic bit open_field(input logic [1:0] size, input logic [1:0] dest,
                                     input logic [31:0] na, output result_type r);
      logic [1:0] sz;
      logic [1:0] dst;
      sz = size;
      dst = dest;
      if (sz == SIZE_NONE && dst == DEST_INNER && spec.mode == MODE_DOUBLE) begin
         sz = spec.s2;
         dst = DEST_OUTER;
      end
      if (sz == SIZE_NONE)
         return close_specifier(na, r);
      spec.dest = dst;
      if (dst == DEST_OUTER)
         spec.s2 = sz;
      else
         spec.fsize = sz;
      bytes_due = (sz == SIZE_LONG) ? 3'd4 : {1'b0, sz};
      gathered = '0;
      spec_phase = PH_GATHER;
      return 1'b0;
   endfunction

   function automatic bit decode_first(input logic [7:0] b, input logic [31:0] na,
                                       output result_type r);
      logic [6:0] code;
      logic [2:0] group;
      code = b[6:0];
      group = code[6:4];
      if (b[7])
         spec.acc = 1'b1;
      if (group == GROUP_REG) begin
         if (kind_held == KIND_MEMORY || kind_held == KIND_PERIPHERAL)
            flag_error(STATUS_ILLEGAL_MODE);
         spec.mode = MODE_REG;
         spec.base = code[3:0];
         return close_specifier(na, r);
      end
      if (group < GROUP_REG) begin
         spec.mode = (group[1:0] == SIZE_NONE) ? MODE_IND : MODE_DISP;
         spec.base = code[3:0];
         return open_field(group[1:0], DEST_INNER, na, r);
      end
      if (group != GROUP_EXTENDED) begin
         if (kind_held == KIND_PERIPHERAL || kind_held == KIND_BITFIELD)
            flag_error(STATUS_ILLEGAL_MODE);
         spec.mode = (group == GROUP_POSTINC) ? MODE_POSTINC : MODE_PREDEC;
         spec.base = code[3:0];
         return close_specifier(na, r);
      end
      case (code)
         CODE_PREFIX_CONTROL, CODE_PREFIX_PAGE: begin
            if (bank_held != BANK_GENERAL)
               flag_error(STATUS_ILLEGAL_MODE);
            bank_held = (code == CODE_PREFIX_CONTROL) ? BANK_CONTROL : BANK_PAGE;
            spec_phase = PH_EA;
            return 1'b0;
         end
         CODE_INDEXED: begin
            spec.mode = MODE_INDEXED;
            spec_phase = PH_IDX1;
            return 1'b0;
         end
         CODE_PCREL: begin
            if (bank_held != BANK_GENERAL)
               flag_error(STATUS_ILLEGAL_MODE);
            spec_phase = PH_PC1;
            return 1'b0;
         end
         CODE_DOUBLE: begin
            spec.mode = MODE_DOUBLE;
            spec_phase = PH_DI;
            return 1'b0;
         end
         CODE_INVALID: begin
            flag_error(STATUS_ILLEGAL_OPND);
            spec.mode = MODE_INVALID;
            return close_specifier(na, r);
         end
         default: begin
            if (code[3]) begin
               spec.mode = MODE_SCALED;
               spec.fsize = code[1:0];
               spec_phase = PH_SCALED;
               return 1'b0;
            end
            if (!code[2] && kind_held != KIND_ANY)
               flag_error(STATUS_ILLEGAL_MODE);
            if (bank_held != BANK_GENERAL)
               flag_error(STATUS_ILLEGAL_MODE);
            spec.mode = code[2] ? MODE_ABS : MODE_IMM;
            return open_field(code[1:0], DEST_VALUE, na, r);
         end
      endcase
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                      input logic [2:0] kind, input logic [31:0] na,
                                      output result_type r);
      logic [31:0] v;
      if (start) begin
         spec = '0;
         bank_held = BANK_GENERAL;
         status_held = STATUS_OK;
         bytes_due = '0;
         gathered = '0;
         kind_held = kind;
         return decode_first(b, na, r);
      end
      case (spec_phase)
         PH_EA: return decode_first(b, na, r);
         PH_SCALED: begin
            take_index(b);
            spec.base = b[3:0];
            return open_field(spec.fsize, DEST_INNER, na, r);
         end
         PH_IDX1: begin
            if (b[7])
               flag_error(STATUS_ILLEGAL_MODE);
            spec.fsize = b[5:4];
            spec.base = b[3:0];
            spec.idx_long = b[6];
            spec_phase = PH_IDX2;
            return 1'b0;
         end
         PH_IDX2, PH_PC2: begin
            take_index(b);
            return open_field(spec.fsize, DEST_INNER, na, r);
         end
         PH_PC1: begin
            spec.fsize = b[5:4];
            if (b[7]) begin
               spec.mode = MODE_PCREL;
               if (b[6] || b[3:0] != 4'h0)
                  flag_error(STATUS_ILLEGAL_MODE);
               return open_field(spec.fsize, DEST_INNER, na, r);
            end
            spec.mode = MODE_PCREL_IDX;
            if (b[3:0] != 4'h0)
               flag_error(STATUS_ILLEGAL_MODE);
            spec.idx_long = b[6];
            spec_phase = PH_PC2;
            return 1'b0;
         end
         PH_DI: begin
            spec.s2 = b[7:6];
            spec.base = b[3:0];
            spec.fsize = b[5:4];
            if (!b[4] || !b[6])
               flag_error(STATUS_ILLEGAL_MODE);
            return open_field(b[5:4], DEST_INNER, na, r);
         end
         PH_GATHER: begin
            gathered = {gathered[23:0], b};
            if (bytes_due != 3'd0)
               bytes_due = bytes_due - 3'd1;
            if (bytes_due != 3'd0)
               return 1'b0;
            if (spec.dest == DEST_OUTER) begin
               spec.outer = sign_widen(gathered, spec.s2);
               return close_specifier(na, r);
            end
            v = sign_widen(gathered, spec.fsize);
            if (spec.dest == DEST_VALUE) begin
               spec.value = v;
               return close_specifier(na, r);
            end
            spec.inner = v;
            if (spec.mode == MODE_DOUBLE)
               return open_field(spec.s2, DEST_OUTER, na, r);
            return close_specifier(na, r);
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100)
         $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   task automatic check_result(input result_type got);
      result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result word arrived with none expected");
         return;
      end
      want = expected_results.pop_front();
      compare_field("addr_mode", got.addr_mode, want.addr_mode);
      compare_field("base_reg", got.base_reg, want.base_reg);
      compare_field("reg_bank", got.reg_bank, want.reg_bank);
      compare_field("index_reg", got.index_reg, want.index_reg);
      compare_field("index_long", got.index_long, want.index_long);
      compare_field("scale_shift", got.scale_shift, want.scale_shift);
      compare_field("field_size", got.field_size, want.field_size);
      compare_field("disp_inner", got.disp_inner, want.disp_inner);
      compare_field("disp_outer", got.disp_outer, want.disp_outer);
      compare_field("value", got.value, want.value);
      compare_field("accumulator", got.accumulator, want.accumulator);
      compare_field("status", got.status, want.status);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result({rsp_addr_mode, rsp_base_reg, rsp_reg_bank, rsp_index_reg,
                          rsp_index_long, rsp_scale_shift, rsp_field_size, rsp_disp_inner,
                          rsp_disp_outer, rsp_value, rsp_accumulator, rsp_status});
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] spec_byte, input logic start,
                            input logic [2:0] kind, input logic [31:0] address);
      result_type outcome;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_spec_byte <= spec_byte;
      req_start_req <= start;
      req_operand_kind <= kind;
      req_next_address <= address;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (decode_byte(spec_byte, start, kind, address, outcome))
         expected_results.push_back(outcome);
   endtask

   task automatic send_specifier(input byte_list_t spec_bytes, input logic [2:0] kind,
                                 input logic [31:0] base_address);
      foreach (spec_bytes[i])
         send_byte(spec_bytes[i], i == 0, kind, base_address + 32'(i) + 32'd1);
   endtask

   function automatic logic [2:0] random_kind();
      return ($urandom_range(0, 2) == 0) ? KIND_ANY : 3'($urandom_range(0, 7));
   endfunction

   function automatic logic [7:0] random_first_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if ($urandom_range(0, 9) < 6)
         b[6:4] = GROUP_EXTENDED;
      return b;
   endfunction

   // Extension bytes are mostly well formed so that the stream reaches the deeper phases.
   function automatic logic [7:0] random_follow_byte();
      logic [7:0] b;
      bit         tidy;
      b = 8'($urandom);
      tidy = ($urandom_range(0, 9) != 0);
      case (spec_phase)
         PH_EA: b = random_first_byte();
         PH_SCALED, PH_IDX2, PH_PC2: if (tidy) b[7:6] = 2'b00;
         PH_IDX1: if (tidy) b[7] = 1'b0;
         PH_PC1: if (tidy) begin
            b[3:0] = 4'h0;
            if (b[7])
               b[6] = 1'b0;
         end
         PH_DI: if (tidy) begin
            b[6] = 1'b1;
            b[4] = 1'b1;
         end
         default: ;
      endcase
      return b;
   endfunction

   task automatic test_register_modes();
      send_specifier('{8'h40}, KIND_ANY, 32'h0000_1000);
      send_specifier('{8'hCF}, KIND_MEMORY, 32'h0000_1010);
      send_specifier('{8'h5A}, KIND_PERIPHERAL, 32'h0000_1020);
      send_specifier('{8'hE3}, KIND_BITFIELD, 32'h0000_1030);
   endtask

   task automatic test_displacement_modes();
      send_specifier('{8'h05}, KIND_PERIPHERAL, 32'h0000_2000);
      send_specifier('{8'h12, 8'h80}, KIND_ANY, 32'h0000_2010);
      send_specifier('{8'h27, 8'h7F, 8'hFF}, KIND_WRITE, 32'h0000_2020);
      send_specifier('{8'hB1, 8'h80, 8'h00, 8'h00, 8'h00}, KIND_ANY, 32'h0000_2030);
   endtask

   task automatic test_immediate_absolute();
      send_specifier('{8'h71, 8'hFF}, KIND_ANY, 32'h0000_3000);
      send_specifier('{8'h73, 8'h7F, 8'hFF, 8'hFF, 8'hFF}, KIND_ANY, 32'h0000_3010);
      send_specifier('{8'h72, 8'h12, 8'h34}, KIND_UNDEFINED, 32'h0000_3020);
      send_specifier('{8'h77, 8'hDE, 8'hAD, 8'hBE, 8'hEF}, KIND_UNDEFINED, 32'h0000_3030);
   endtask

   task automatic test_indexed_modes();
      send_specifier('{8'h79, 8'h3A, 8'h80}, KIND_ANY, 32'h0000_4000);
      send_specifier('{8'h78, 8'hC1}, KIND_ANY, 32'h0000_4010);
      send_specifier('{8'h7C, 8'h6F, 8'h25, 8'h80, 8'h00}, KIND_MEMORY, 32'h0000_4020);
      send_specifier('{8'h7C, 8'h80, 8'h00}, KIND_ANY, 32'h0000_4030);
   endtask

   task automatic test_pc_relative();
      send_specifier('{8'h7D, 8'hB0, 8'hFF, 8'hFF, 8'hFF, 8'hFE}, KIND_ANY, 32'hFFFF_FFF0);
      send_specifier('{8'h7D, 8'hC1}, KIND_ANY, 32'h0000_5000);
      send_specifier('{8'h7D, 8'h50, 8'h13, 8'h7F}, KIND_ANY, 32'hFFFF_FFFC);
   endtask

   task automatic test_double_indirect();
      send_specifier('{8'h7E, 8'hD4, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01}, KIND_ANY,
                     32'h0000_6000);
      send_specifier('{8'h7E, 8'h0C}, KIND_ANY, 32'h0000_6010);
      send_specifier('{8'h7E, 8'hA3, 8'h12, 8'h34, 8'hFF, 8'hFF}, KIND_ANY, 32'h0000_6020);
   endtask

   task automatic test_bank_prefix();
      send_specifier('{8'h70, 8'h43}, KIND_ANY, 32'h0000_7000);
      send_specifier('{8'h74, 8'h70, 8'hC5}, KIND_ANY, 32'h0000_7010);
      send_specifier('{8'h70, 8'h71, 8'h05}, KIND_ANY, 32'h0000_7020);
      send_specifier('{8'hF4, 8'h7D, 8'h80}, KIND_ANY, 32'h0000_7030);
   endtask

   task automatic test_framing();
      send_specifier('{8'h7C, 8'h10}, KIND_ANY, 32'h0000_8000);
      send_specifier('{8'hFF}, KIND_ANY, 32'h0000_8010);
      send_byte(8'h40, 1'b0, KIND_ANY, 32'h0000_8020);
      send_specifier('{8'h70, 8'h7F}, KIND_ANY, 32'h0000_8030);
   endtask

   task automatic test_random_stream(input int words, input int gap_pct, input int stall_pct);
      int sent;
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 29) == 0)
            repeat ($urandom_range(1, 3))
               send_byte(8'($urandom), 1'b0, random_kind(), $urandom);
         send_byte(random_first_byte(), 1'b1, random_kind(), $urandom);
         sent++;
         while (spec_phase != PH_IDLE && $urandom_range(0, 49) != 0) begin
            send_byte(random_follow_byte(), 1'b0, random_kind(), $urandom);
            sent++;
         end
      end
   endtask

   initial begin
      spec_phase = PH_IDLE;
      bytes_due = '0;
      bank_held = BANK_GENERAL;
      kind_held = KIND_ANY;
      spec = '0;
      gathered = '0;
      status_held = STATUS_OK;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_register_modes();
      test_displacement_modes();
      test_immediate_absolute();
      test_indexed_modes();
      test_pc_relative();
      test_double_indirect();
      test_bank_prefix();
      test_framing();
      test_random_stream(250, 0, 0);
      test_random_stream(250, 83, 0);
      test_random_stream(250, 0, 83);
      test_random_stream(250, 22, 22);
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/easd_pkg.sv
rtl/easd_decode.sv
rtl/easd_outbuf.sv
rtl/effective_address_specifier_decoder.sv
dv/effective_address_specifier_decoder_tb.sv
